/* rtl/gasp_pkg.sv */
`timescale 1ns / 1ps

package gasp_pkg;

    localparam int MAX_GLYPHS_DEF = 256;
    localparam int MIN_SIDE_DEF   = 32;
    localparam int MAX_SIDE_DEF   = 2048;

    localparam int PEN_LIMIT   = 4095;
    localparam int COORD_LIMIT = 2047;

    localparam logic FN_LOAD  = 1'b0;
    localparam logic FN_FETCH = 1'b1;

    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_OVER   = 2'd2;

    typedef struct packed {
        logic [7:0]        width;
        logic [7:0]        rows;
        logic signed [8:0] bearing;
    } t_glyph;

    typedef struct packed {
        logic x_over;
        logic y_over;
    } t_step_flags;

endpackage

/* rtl/gasp_store.sv */
`timescale 1ns / 1ps

module gasp_store #(
    parameter int DEPTH = gasp_pkg::MAX_GLYPHS_DEF,
    parameter int AW    = 8
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  gasp_pkg::t_glyph i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output gasp_pkg::t_glyph o_rdata
);

    gasp_pkg::t_glyph r_mem [DEPTH];
    gasp_pkg::t_glyph r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gasp_step.sv */
`timescale 1ns / 1ps

module gasp_step #(
    parameter int PW = 12,
    parameter int SW = 12
) (
    input  logic [PW-1:0]         i_x,
    input  logic [PW-1:0]         i_y,
    input  logic [PW-1:0]         i_lim,
    input  logic [SW-1:0]         i_side,
    input  logic [9:0]            i_lh,
    input  logic [7:0]            i_max_top,
    input  gasp_pkg::t_glyph      i_glyph,
    input  logic [9:0]            i_t,
    output gasp_pkg::t_step_flags o_flags,
    output logic [PW-1:0]         o_x_adv,
    output logic [PW-1:0]         o_y_wrap,
    output logic [9:0]            o_t,
    output logic [8:0]            o_off
);

    logic [PW:0]        side_e;
    logic [PW:0]        x_sum;
    logic [PW:0]        y_line;
    logic [PW:0]        y_sum;
    logic [PW:0]        lim_e;
    logic signed [9:0]  diff;

    always_comb begin
        side_e = (PW+1)'(i_side);
        lim_e  = {1'b0, i_lim};
        x_sum  = {1'b0, i_x} + (PW+1)'(i_glyph.width) + (PW+1)'(1);
        y_line = {1'b0, i_y} + (PW+1)'(i_lh) + (PW+1)'(1);
        y_sum  = {1'b0, i_y} + (PW+1)'(i_t);

        o_flags.x_over = x_sum > side_e;
        o_flags.y_over = y_sum > side_e;
        o_x_adv  = (x_sum > lim_e) ? i_lim : x_sum[PW-1:0];
        o_y_wrap = (y_line > lim_e) ? i_lim : y_line[PW-1:0];

        diff  = $signed({2'b00, i_max_top}) - $signed({i_glyph.bearing[8], i_glyph.bearing});
        o_off = diff[9] ? 9'd0 : diff[8:0];
        o_t   = {1'b0, o_off} + {2'b00, i_glyph.rows} + 10'd1;
    end

endmodule

/* rtl/glyph_atlas_shelf_packer.sv */
`timescale 1ns / 1ps

// channel | valid       | ready       | payload
// input   | i_in_valid  | o_in_ready  | i_func i_glyph_width i_glyph_rows i_top_bearing
// output  | o_out_valid | i_out_ready | o_cell_x o_shelf_y o_bearing_offset o_atlas_side
//         |             |             | o_line_height o_status o_last
//
// a load is written straight from the idle state; a fetch of a placement steps through read, wrap and check
// the first fetch first runs the fit test: read, wrap and check per stored glyph per tried side,
// up to one pass for each doubling from the smallest side, all through one step unit
// reset clears counts and maxima, sets the side to the smallest and the pens to one; the glyph store needs no clearing
// a new item is taken when idle and the output register is free or being emptied

module glyph_atlas_shelf_packer #(
    parameter int MAX_GLYPHS = gasp_pkg::MAX_GLYPHS_DEF,
    parameter int MIN_SIDE   = gasp_pkg::MIN_SIDE_DEF,
    parameter int MAX_SIDE   = gasp_pkg::MAX_SIDE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [7:0]        i_glyph_width,
    input  logic [7:0]        i_glyph_rows,
    input  logic signed [8:0] i_top_bearing,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [10:0]       o_cell_x,
    output logic [10:0]       o_shelf_y,
    output logic [8:0]        o_bearing_offset,
    output logic [11:0]       o_atlas_side,
    output logic [9:0]        o_line_height,
    output logic [1:0]        o_status,
    output logic              o_last
);

    localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CW = $clog2(MAX_GLYPHS + 1);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int PW = ($clog2(MAX_SIDE + 1024) > 12) ? $clog2(MAX_SIDE + 1024) : 12;
    localparam logic START_DONE = (MIN_SIDE >= MAX_SIDE);
    localparam logic [SW-1:0] SIDE_LO = START_DONE ? SW'(MAX_SIDE) : SW'(MIN_SIDE);
    localparam logic [SW-1:0] SIDE_HI = SW'(MAX_SIDE);
    localparam logic [PW-1:0] PEN_ONE = PW'(1);
    localparam logic [PW-1:0] LIM_PLACE = PW'(gasp_pkg::PEN_LIMIT);
    localparam logic [PW-1:0] LIM_FIT = '1;
    localparam logic [PW-1:0] COORD_MAX = PW'(gasp_pkg::COORD_LIMIT);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_WRAP = 4'b0100,
        S_CHK  = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_max_top, n_max_top;
    logic [8:0]    r_max_bot, n_max_bot;
    logic [SW-1:0] r_side, n_side;
    logic [AW-1:0] r_idx, n_idx;
    logic [PW-1:0] r_x, n_x;
    logic [PW-1:0] r_y, n_y;
    logic          r_packed, n_packed;
    logic          r_fit, n_fit;
    logic [9:0]    r_t, n_t;
    logic          r_ovalid, n_ovalid;
    logic [10:0]   r_o_x, n_o_x;
    logic [10:0]   r_o_y, n_o_y;
    logic [8:0]    r_o_off, n_o_off;
    logic [11:0]   r_o_side, n_o_side;
    logic [9:0]    r_o_lh, n_o_lh;
    logic [1:0]    r_o_status, n_o_status;
    logic          r_o_last, n_o_last;

    logic                  in_fire;
    logic                  we;
    logic                  full;
    logic                  is_last;
    logic [9:0]            lh;
    logic signed [9:0]     bottom;
    logic [SW:0]           side2;
    gasp_pkg::t_glyph      wdata;
    gasp_pkg::t_glyph      rdata;
    gasp_pkg::t_step_flags flags;
    logic [PW-1:0]         x_adv;
    logic [PW-1:0]         y_wrap;
    logic [9:0]            t_new;
    logic [8:0]            off;

    assign o_in_ready = (r_state == S_IDLE) && (!r_ovalid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;

    assign wdata.width   = i_glyph_width;
    assign wdata.rows    = i_glyph_rows;
    assign wdata.bearing = i_top_bearing;

    gasp_store #(
        .DEPTH (MAX_GLYPHS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    gasp_step #(
        .PW (PW),
        .SW (SW)
    ) u_step (
        .i_x       (r_x),
        .i_y       (r_y),
        .i_lim     (r_fit ? LIM_FIT : LIM_PLACE),
        .i_side    (r_side),
        .i_lh      (lh),
        .i_max_top (r_max_top),
        .i_glyph   (rdata),
        .i_t       (r_t),
        .o_flags   (flags),
        .o_x_adv   (x_adv),
        .o_y_wrap  (y_wrap),
        .o_t       (t_new),
        .o_off     (off)
    );

    always_comb begin
        lh      = {2'b00, r_max_top} + {1'b0, r_max_bot};
        full    = r_count >= CW'(MAX_GLYPHS);
        is_last = ((CW+1)'(r_idx) + (CW+1)'(1)) == (CW+1)'(r_count);
        bottom  = $signed({2'b00, i_glyph_rows}) - $signed({i_top_bearing[8], i_top_bearing});
        side2   = {r_side, 1'b0};

        n_state    = r_state;
        n_count    = r_count;
        n_max_top  = r_max_top;
        n_max_bot  = r_max_bot;
        n_side     = r_side;
        n_idx      = r_idx;
        n_x        = r_x;
        n_y        = r_y;
        n_packed   = r_packed;
        n_fit      = r_fit;
        n_t        = r_t;
        n_ovalid   = r_ovalid;
        n_o_x      = r_o_x;
        n_o_y      = r_o_y;
        n_o_off    = r_o_off;
        n_o_side   = r_o_side;
        n_o_lh     = r_o_lh;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        we         = 1'b0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_func == gasp_pkg::FN_LOAD) begin
                        if (!r_packed && !full) begin
                            we      = 1'b1;
                            n_count = r_count + CW'(1);
                            if (!i_top_bearing[8] && (i_top_bearing[7:0] > r_max_top)) begin
                                n_max_top = i_top_bearing[7:0];
                            end
                            if (!bottom[9] && (bottom[8:0] > r_max_bot)) begin
                                n_max_bot = bottom[8:0];
                            end
                        end
                    end else if (r_count == '0) begin
                        n_ovalid   = 1'b1;
                        n_o_x      = '0;
                        n_o_y      = '0;
                        n_o_off    = '0;
                        n_o_side   = '0;
                        n_o_lh     = '0;
                        n_o_status = gasp_pkg::ST_EMPTY;
                        n_o_last   = 1'b0;
                    end else if (r_packed) begin
                        n_state = S_RD;
                    end else begin
                        n_side   = SIDE_LO;
                        n_idx    = '0;
                        n_x      = PEN_ONE;
                        n_y      = PEN_ONE;
                        n_packed = START_DONE;
                        n_fit    = !START_DONE;
                        n_state  = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_WRAP;
            end
            S_WRAP: begin
                if (flags.x_over) begin
                    n_x = PEN_ONE;
                    n_y = y_wrap;
                end
                n_t     = t_new;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_fit) begin
                    n_state = S_RD;
                    if (flags.y_over) begin
                        n_idx = '0;
                        n_x   = PEN_ONE;
                        n_y   = PEN_ONE;
                        if (side2 < (SW+1)'(MAX_SIDE)) begin
                            n_side = side2[SW-1:0];
                        end else begin
                            n_side   = SIDE_HI;
                            n_fit    = 1'b0;
                            n_packed = 1'b1;
                        end
                    end else if (is_last) begin
                        n_idx    = '0;
                        n_x      = PEN_ONE;
                        n_y      = PEN_ONE;
                        n_fit    = 1'b0;
                        n_packed = 1'b1;
                    end else begin
                        n_idx = r_idx + AW'(1);
                        n_x   = x_adv;
                    end
                end else begin
                    n_ovalid   = 1'b1;
                    n_o_x      = (r_x > COORD_MAX) ? COORD_MAX[10:0] : r_x[10:0];
                    n_o_y      = (r_y > COORD_MAX) ? COORD_MAX[10:0] : r_y[10:0];
                    n_o_off    = off;
                    n_o_side   = 12'(r_side);
                    n_o_lh     = lh;
                    n_o_status = (flags.x_over || flags.y_over) ? gasp_pkg::ST_OVER
                                                                : gasp_pkg::ST_PLACED;
                    n_o_last   = is_last;
                    if (is_last) begin
                        n_idx = '0;
                        n_x   = PEN_ONE;
                        n_y   = PEN_ONE;
                    end else begin
                        n_idx = r_idx + AW'(1);
                        n_x   = x_adv;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_max_top <= '0;
            r_max_bot <= '0;
            r_side    <= SIDE_LO;
            r_idx     <= '0;
            r_x       <= PEN_ONE;
            r_y       <= PEN_ONE;
            r_packed  <= 1'b0;
            r_fit     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_max_top <= n_max_top;
            r_max_bot <= n_max_bot;
            r_side    <= n_side;
            r_idx     <= n_idx;
            r_x       <= n_x;
            r_y       <= n_y;
            r_packed  <= n_packed;
            r_fit     <= n_fit;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t        <= n_t;
        r_o_x      <= n_o_x;
        r_o_y      <= n_o_y;
        r_o_off    <= n_o_off;
        r_o_side   <= n_o_side;
        r_o_lh     <= n_o_lh;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_out_valid      = r_ovalid;
    assign o_cell_x         = r_o_x;
    assign o_shelf_y        = r_o_y;
    assign o_bearing_offset = r_o_off;
    assign o_atlas_side     = r_o_side;
    assign o_line_height    = r_o_lh;
    assign o_status         = r_o_status;
    assign o_last           = r_o_last;

`ifndef NO_ASSERTIONS
    a_fit_unpacked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fit |-> !r_packed)
        else $error("fit pass running after packing");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_GLYPHS))
        else $error("glyph count beyond capacity");

    a_empty_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == gasp_pkg::ST_EMPTY)) |-> (r_count == '0))
        else $error("empty status with glyphs stored");

    a_pack_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_packed) |-> ((r_state == S_RD) && (r_idx == '0)))
        else $error("placement not started at first glyph");

    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_packed |=> (r_count == $past(r_count)))
        else $error("load taken after packing");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_GLYPHS = gasp_pkg::MAX_GLYPHS_DEF;
    localparam int MIN_SIDE   = gasp_pkg::MIN_SIDE_DEF;
    localparam int MAX_SIDE   = gasp_pkg::MAX_SIDE_DEF;

    localparam int ACTIVE_LOADS  = MAX_GLYPHS;
    localparam int FETCH_BEATS   = 950;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SETTLE_LIMIT  = 200000;

    typedef struct packed {
        logic [10:0] cell_x;
        logic [10:0] shelf_y;
        logic [8:0]  offset;
        logic [11:0] side;
        logic [9:0]  line_h;
        logic [1:0]  status;
        logic        last;
    } t_placement;

    class shelf_placement_board;
        logic [7:0] width_mem [MAX_GLYPHS];
        logic [7:0] rows_mem [MAX_GLYPHS];
        int         bearing_mem [MAX_GLYPHS];
        int         glyphs;
        int         top_max;
        int         bottom_max;
        int         side;
        int         fetch_at;
        int         pen_x;
        int         pen_y;
        bit         layout_fixed;
        int         errors;
        int         places_seen;
        t_placement expected_places [$];

        function new();
            glyphs = 0;
            top_max = 0;
            bottom_max = 0;
            side = MIN_SIDE;
            fetch_at = 0;
            pen_x = 1;
            pen_y = 1;
            layout_fixed = 1'b0;
            errors = 0;
            places_seen = 0;
        endfunction

        function int clip(int v, int lim);
            return (v > lim) ? lim : v;
        endfunction

        function int drop_below_top(int i);
            int d;
            d = top_max - bearing_mem[i];
            return (d < 0) ? 0 : d;
        endfunction

        // shelf walk with x advanced after a wrap, checking height only
        function bit fits_side(int s);
            int lh;
            int x;
            int y;
            lh = top_max + bottom_max;
            x = 1;
            y = 1;
            for (int i = 0; i < glyphs; i++) begin
                if (x + int'(width_mem[i]) + 1 > s) begin
                    x = 1;
                    y += lh + 1;
                end
                x += int'(width_mem[i]) + 1;
                if (y + drop_below_top(i) + int'(rows_mem[i]) + 1 > s)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_beat(logic f, logic [7:0] w, logic [7:0] r,
                                logic signed [8:0] tb);
            int top;
            int bottom;
            int lh;
            int i;
            int wi;
            int off;
            t_placement p;
            if (f == gasp_pkg::FN_LOAD) begin
                if (layout_fixed || glyphs >= MAX_GLYPHS)
                    return;
                top = int'(tb);
                width_mem[glyphs] = w;
                rows_mem[glyphs] = r;
                bearing_mem[glyphs] = top;
                glyphs++;
                if (top > top_max)
                    top_max = top;
                bottom = int'(r) - top;
                if (bottom > bottom_max)
                    bottom_max = bottom;
                return;
            end
            p = '0;
            if (glyphs == 0) begin
                p.status = gasp_pkg::ST_EMPTY;
                expected_places.push_back(p);
                return;
            end
            if (!layout_fixed) begin
                side = MIN_SIDE;
                while (side < MAX_SIDE && !fits_side(side))
                    side = side * 2;
                if (side > MAX_SIDE)
                    side = MAX_SIDE;
                layout_fixed = 1'b1;
                fetch_at = 0;
                pen_x = 1;
                pen_y = 1;
            end
            lh = top_max + bottom_max;
            i = (fetch_at >= glyphs) ? 0 : fetch_at;
            wi = int'(width_mem[i]);
            if (pen_x + wi + 1 > side) begin
                pen_x = 1;
                pen_y = clip(pen_y + lh + 1, gasp_pkg::PEN_LIMIT);
            end
            off = drop_below_top(i);
            if (pen_x + wi + 1 > side || pen_y + off + int'(rows_mem[i]) + 1 > side)
                p.status = gasp_pkg::ST_OVER;
            else
                p.status = gasp_pkg::ST_PLACED;
            p.cell_x = 11'(clip(pen_x, gasp_pkg::COORD_LIMIT));
            p.shelf_y = 11'(clip(pen_y, gasp_pkg::COORD_LIMIT));
            p.offset = 9'(off);
            p.side = 12'(side);
            p.line_h = 10'(lh);
            p.last = (i + 1 == glyphs);
            expected_places.push_back(p);
            pen_x = clip(pen_x + wi + 1, gasp_pkg::PEN_LIMIT);
            if (i + 1 >= glyphs) begin
                fetch_at = 0;
                pen_x = 1;
                pen_y = 1;
            end else begin
                fetch_at = i + 1;
            end
        endfunction

        task report(string what);
            $display("mismatch at placement %0d: %s", places_seen, what);
            errors++;
        endtask

        task check_field(string name, logic [11:0] got, logic [11:0] want);
            if (got !== want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_placement(t_placement got);
            t_placement want;
            if (expected_places.size() == 0) begin
                report($sformatf("unexpected beat x=%0d y=%0d status=%0d",
                                 got.cell_x, got.shelf_y, got.status));
            end else begin
                want = expected_places.pop_front();
                check_field("cell_x", 12'(got.cell_x), 12'(want.cell_x));
                check_field("shelf_y", 12'(got.shelf_y), 12'(want.shelf_y));
                check_field("bearing_offset", 12'(got.offset), 12'(want.offset));
                check_field("atlas_side", got.side, want.side);
                check_field("line_height", 12'(got.line_h), 12'(want.line_h));
                check_field("status", 12'(got.status), 12'(want.status));
                check_field("last", 12'(got.last), 12'(want.last));
            end
            places_seen++;
        endtask

        task check_drained();
            if (expected_places.size() != 0)
                report($sformatf("%0d placements never arrived", expected_places.size()));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_func;
    logic [7:0]        i_glyph_width;
    logic [7:0]        i_glyph_rows;
    logic signed [8:0] i_top_bearing;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [10:0]       o_cell_x;
    logic [10:0]       o_shelf_y;
    logic [8:0]        o_bearing_offset;
    logic [11:0]       o_atlas_side;
    logic [9:0]        o_line_height;
    logic [1:0]        o_status;
    logic              o_last;

    shelf_placement_board board;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    glyph_atlas_shelf_packer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_glyph_width    (i_glyph_width),
        .i_glyph_rows     (i_glyph_rows),
        .i_top_bearing    (i_top_bearing),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cell_x         (o_cell_x),
        .o_shelf_y        (o_shelf_y),
        .o_bearing_offset (o_bearing_offset),
        .o_atlas_side     (o_atlas_side),
        .o_line_height    (o_line_height),
        .o_status         (o_status),
        .o_last           (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("** glyph_atlas_shelf_packer: FAILED **");
        $finish;
    end

    // sender works in bursts, gaps land anywhere in the block's work
    task automatic send_item(input logic f, input logic [7:0] w, input logic [7:0] r,
                             input logic signed [8:0] tb);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_func = f;
        i_glyph_width = w;
        i_glyph_rows = r;
        i_top_bearing = tb;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        board.note_beat(f, w, r, tb);
    endtask

    task automatic send_small_load();
        int top;
        top = int'($urandom_range(0, 9)) - 3;
        send_item(gasp_pkg::FN_LOAD, 8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                  9'(top));
    endtask

    task automatic send_any_load();
        send_item(gasp_pkg::FN_LOAD, 8'($urandom), 8'($urandom), 9'($urandom));
    endtask

    // receiver stall pattern: free running, coin toss, sparse, or periodic
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0: i_out_ready = 1'b1;
            1: i_out_ready = ($urandom_range(0, 1) == 0);
            2: i_out_ready = ($urandom_range(0, 3) == 0);
            default: i_out_ready = ((stall_left % 8) < 5);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_placement('{cell_x: o_cell_x, shelf_y: o_shelf_y,
                                    offset: o_bearing_offset, side: o_atlas_side,
                                    line_h: o_line_height, status: o_status,
                                    last: o_last});
    end

    initial begin
        int settle;
        board = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = gasp_pkg::FN_LOAD;
        i_glyph_width = '0;
        i_glyph_rows = '0;
        i_top_bearing = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fetch before anything is loaded
        send_item(gasp_pkg::FN_FETCH, 8'd0, 8'd0, 9'sd0);
        send_item(gasp_pkg::FN_FETCH, 8'hFF, 8'hFF, -9'sd1);

        // zero glyph, full-width glyph, negative bottom, negative tops
        send_item(gasp_pkg::FN_LOAD, 8'd0, 8'd0, 9'sd0);
        send_item(gasp_pkg::FN_LOAD, 8'd255, 8'd0, 9'sd0);
        send_item(gasp_pkg::FN_LOAD, 8'd1, 8'd0, 9'sd5);
        send_item(gasp_pkg::FN_LOAD, 8'd3, 8'd4, -9'sd1);
        send_item(gasp_pkg::FN_LOAD, 8'd0, 8'd7, -9'sd3);
        send_item(gasp_pkg::FN_LOAD, 8'd7, 8'd7, 9'sd6);
        for (int n = 6; n < ACTIVE_LOADS; n++)
            send_small_load();

        // store full, these must leave no trace
        send_item(gasp_pkg::FN_LOAD, 8'd255, 8'd255, 9'h100);
        send_item(gasp_pkg::FN_LOAD, 8'd0, 8'd255, 9'sd255);
        send_item(gasp_pkg::FN_LOAD, 8'hAA, 8'h55, 9'h0AA);
        send_item(gasp_pkg::FN_LOAD, 8'h55, 8'hAA, 9'h155);

        // placements wrap round the glyph list several times, loads ignored
        for (int n = 0; n < FETCH_BEATS; n++) begin
            if ($urandom_range(0, 6) == 0)
                send_any_load();
            send_item(gasp_pkg::FN_FETCH, 8'($urandom), 8'($urandom), 9'($urandom));
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;

        settle = 0;
        while (board.expected_places.size() != 0 && settle < SETTLE_LIMIT) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        board.check_drained();
        if (board.errors == 0)
            $display("** glyph_atlas_shelf_packer: PASSED **");
        else
            $display("** glyph_atlas_shelf_packer: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/gasp_pkg.sv
rtl/gasp_store.sv
rtl/gasp_step.sv
rtl/glyph_atlas_shelf_packer.sv
verif/testbench.sv
